[hdl/gcd_pkg.sv]
`timescale 1ns / 1ps

package gcd_pkg;

  localparam int CORDIC_STAGES_DEF = 24;
  localparam int CW                = 34;
  localparam int SQRT_STEPS        = 31;

  typedef logic signed [CW-1:0] cw_t;

  typedef struct packed {
    cw_t x;
    cw_t y;
    cw_t z;
  } rot_t;

  typedef rot_t [3:0] rot4_t;

  typedef struct packed {
    logic [61:0] n;
    logic [61:0] res;
  } sq_t;

  typedef sq_t [1:0] sq2_t;

  localparam cw_t GAIN_Q30 = 34'sh026DD3B6A;

  localparam logic [31:0] ATAN_SMALL [10] = '{
    32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76,
    32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD
  };

  // arctangent of 2^-i in Q2.30
  function automatic cw_t atan_q30(input int i);
    cw_t a;
    a = '0;
    if (i < 10) begin
      a = cw_t'(ATAN_SMALL[i[3:0]]);
    end else if (i <= 30) begin
      a = cw_t'(34'd1 << (30 - i));
    end
    return a;
  endfunction

endpackage

[hdl/gcd_rot_cell.sv]
`timescale 1ns / 1ps

// One rotation-mode CORDIC step on four independent lanes.
module gcd_rot_cell #(
  parameter int STAGE = 0
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  gcd_pkg::rot4_t    in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output gcd_pkg::rot4_t    out_data
);

  localparam gcd_pkg::cw_t ANG = gcd_pkg::atan_q30(STAGE);

  logic           v_r;
  gcd_pkg::rot4_t d_r, d_nxt;

  always_comb begin
    for (int l = 0; l < 4; l++) begin
      if (!in_data[l].z[gcd_pkg::CW-1]) begin
        d_nxt[l].x = in_data[l].x - (in_data[l].y >>> STAGE);
        d_nxt[l].y = in_data[l].y + (in_data[l].x >>> STAGE);
        d_nxt[l].z = in_data[l].z - ANG;
      end else begin
        d_nxt[l].x = in_data[l].x + (in_data[l].y >>> STAGE);
        d_nxt[l].y = in_data[l].y - (in_data[l].x >>> STAGE);
        d_nxt[l].z = in_data[l].z + ANG;
      end
    end
  end

  assign in_ready  = !v_r || out_ready;
  assign out_valid = v_r;
  assign out_data  = d_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (in_ready) begin
      v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      d_r <= d_nxt;
    end
  end

endmodule

[hdl/gcd_sqrt_cell.sv]
`timescale 1ns / 1ps

// One result bit of a restoring square root on two lanes.
module gcd_sqrt_cell #(
  parameter int STAGE = 0
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  gcd_pkg::sq2_t  in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output gcd_pkg::sq2_t  out_data
);

  localparam logic [61:0] BIT = 62'd1 << (2 * (gcd_pkg::SQRT_STEPS - 1 - STAGE));

  logic          v_r;
  gcd_pkg::sq2_t d_r, d_nxt;
  logic [61:0]   trial [2];

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      trial[l] = in_data[l].res + BIT;
      if (in_data[l].n >= trial[l]) begin
        d_nxt[l].n   = in_data[l].n - trial[l];
        d_nxt[l].res = (in_data[l].res >> 1) + BIT;
      end else begin
        d_nxt[l].n   = in_data[l].n;
        d_nxt[l].res = in_data[l].res >> 1;
      end
    end
  end

  assign in_ready  = !v_r || out_ready;
  assign out_valid = v_r;
  assign out_data  = d_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (in_ready) begin
      v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      d_r <= d_nxt;
    end
  end

endmodule

[hdl/gcd_vec_cell.sv]
`timescale 1ns / 1ps

// One vectoring-mode CORDIC step: drives y toward zero, collects angle in z.
module gcd_vec_cell #(
  parameter int STAGE = 0
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  gcd_pkg::rot_t in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output gcd_pkg::rot_t out_data
);

  localparam gcd_pkg::cw_t ANG = gcd_pkg::atan_q30(STAGE);

  logic          v_r;
  gcd_pkg::rot_t d_r, d_nxt;

  always_comb begin
    if (!in_data.y[gcd_pkg::CW-1] && (in_data.y != '0)) begin
      d_nxt.x = in_data.x + (in_data.y >>> STAGE);
      d_nxt.y = in_data.y - (in_data.x >>> STAGE);
      d_nxt.z = in_data.z + ANG;
    end else begin
      d_nxt.x = in_data.x - (in_data.y >>> STAGE);
      d_nxt.y = in_data.y + (in_data.x >>> STAGE);
      d_nxt.z = in_data.z - ANG;
    end
  end

  assign in_ready  = !v_r || out_ready;
  assign out_valid = v_r;
  assign out_data  = d_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (in_ready) begin
      v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      d_r <= d_nxt;
    end
  end

endmodule

[hdl/great_circle_distance_top.sv]
`timescale 1ns / 1ps

// Haversine great-circle distance between two positions given in 1e-7 degree
// units, on a sphere of radius 6378.137 km, result in whole meters (rounded to
// 0.1 m, then truncated). Fully pipelined: one item per clock when the output
// side keeps up. Its two CORDIC chains have CORDIC_STAGES cells each and the
// square root chain has 31 cells; every cell holds its own valid bit, so bubbles
// collapse and new items are taken while a finished result waits at the output.
module great_circle_distance_top #(
  parameter int CORDIC_STAGES = gcd_pkg::CORDIC_STAGES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [30:0] in_first_latitude,
  input  logic signed [31:0] in_first_longitude,
  input  logic signed [30:0] in_second_latitude,
  input  logic signed [31:0] in_second_longitude,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [24:0]        out_distance_meters
);

  localparam int N  = CORDIC_STAGES;
  localparam int SQ = gcd_pkg::SQRT_STEPS;

  localparam logic [63:0] PI_Q60  = 64'h3243F6A8885A308D;
  localparam logic [63:0] CONV_W  = (PI_Q60 + 64'd1800000000) / 64'd3600000000;
  localparam logic [29:0] CONV_M  = CONV_W[29:0];
  localparam logic [61:0] ONE_Q60 = 62'd1 << 60;
  localparam logic [30:0] ONE_Q30 = 31'd1 << 30;
  localparam logic [57:0] TWO_RADIUS_DM = 58'd127562740;
  localparam logic [63:0] RECIP_10 = 64'h00000000CCCCCCCD;

  localparam logic signed [30:0] LAT_LIMIT = 31'sd900000000;
  localparam logic signed [33:0] HALF_TURN = 34'sd1800000000;
  localparam logic signed [33:0] FULL_TURN = 34'sd3600000000;

  function automatic logic signed [30:0] sat_lat(input logic signed [30:0] v);
    logic signed [30:0] r;
    r = v;
    if (v > LAT_LIMIT) begin
      r = LAT_LIMIT;
    end else if (v < -LAT_LIMIT) begin
      r = -LAT_LIMIT;
    end
    return r;
  endfunction

  function automatic logic [33:0] mag34(input logic signed [33:0] v);
    return v[33] ? 34'(-v) : 34'(v);
  endfunction

  function automatic logic [30:0] clamp_mag(input gcd_pkg::cw_t v);
    logic [33:0] m;
    m = mag34(v);
    return (m > 34'(ONE_Q30)) ? ONE_Q30 : m[30:0];
  endfunction

  function automatic logic [30:0] clamp_unit(input gcd_pkg::cw_t v);
    logic [30:0] r;
    if (v[gcd_pkg::CW-1]) begin
      r = '0;
    end else if (v > gcd_pkg::cw_t'(ONE_Q30)) begin
      r = ONE_Q30;
    end else begin
      r = v[30:0];
    end
    return r;
  endfunction

  // ---------------- stage 1: saturate, differences, magnitudes
  logic               v1_r, rdy1;
  logic [31:0]        u1_r [4];
  logic [31:0]        u1_nxt [4];
  logic signed [30:0] lat1s, lat2s;
  logic signed [33:0] dlat, dlon_raw, dlon;
  logic [33:0]        m_lat1, m_lat2, m_dlat, m_dlon;

  always_comb begin
    lat1s    = sat_lat(in_first_latitude);
    lat2s    = sat_lat(in_second_latitude);
    dlat     = 34'(lat1s) - 34'(lat2s);
    dlon_raw = 34'(in_first_longitude) - 34'(in_second_longitude);
    if (dlon_raw > HALF_TURN) begin
      dlon = dlon_raw - FULL_TURN;
    end else if (dlon_raw < -HALF_TURN) begin
      dlon = dlon_raw + FULL_TURN;
    end else begin
      dlon = dlon_raw;
    end
    m_lat1    = mag34(34'(lat1s));
    m_lat2    = mag34(34'(lat2s));
    m_dlat    = mag34(dlat);
    m_dlon    = mag34(dlon);
    u1_nxt[0] = m_dlat[31:0];
    u1_nxt[1] = m_dlon[31:0];
    u1_nxt[2] = {m_lat1[30:0], 1'b0};
    u1_nxt[3] = {m_lat2[30:0], 1'b0};
  end

  // ---------------- stage 2: units to half-angle radians (product)
  logic        v2_r, rdy2;
  logic [61:0] p2_r [4];

  // ---------------- rotation chain
  gcd_pkg::rot4_t rot_d [N+1];
  logic           rot_v [N+1];
  logic           rot_rdy [N+1];

  // ---------------- stage 4..8
  logic        v4_r, rdy4;
  logic [30:0] sa4_r, sb4_r, c14_r, c24_r;
  logic        v5_r, rdy5;
  logic [61:0] p15_r;
  logic [30:0] t5_r, uu5_r;
  logic        v6_r, rdy6;
  logic [61:0] p16_r, tu6_r;
  logic        v7_r, rdy7;
  logic [61:0] hs7_r;
  logic        v8_r, rdy8;
  logic [61:0] h8_r, g8_r;
  logic [61:0] h8_nxt;

  // ---------------- square root chain
  gcd_pkg::sq2_t sq_d [SQ+1];
  logic          sq_v [SQ+1];
  logic          sq_rdy [SQ+1];

  // ---------------- vectoring chain
  gcd_pkg::rot_t vec_d [N+1];
  logic          vec_v [N+1];
  logic          vec_rdy [N+1];

  // ---------------- stage 9..12
  logic        v9_r, rdy9;
  logic [57:0] p9_r;
  logic [30:0] zc;
  logic        v10_r, rdy10;
  logic [27:0] tenths10_r;
  logic        v11_r, rdy11;
  logic [63:0] q11_r;
  logic        v12_r, rdy12;
  logic [24:0] dist12_r;

  // ready chain, back to front
  assign rdy12 = !v12_r || out_ready;
  assign rdy11 = !v11_r || rdy12;
  assign rdy10 = !v10_r || rdy11;
  assign rdy9  = !v9_r  || rdy10;
  assign vec_rdy[N] = rdy9;
  assign sq_rdy[SQ] = vec_rdy[0];
  assign rdy8  = !v8_r  || sq_rdy[0];
  assign rdy7  = !v7_r  || rdy8;
  assign rdy6  = !v6_r  || rdy7;
  assign rdy5  = !v5_r  || rdy6;
  assign rdy4  = !v4_r  || rdy5;
  assign rot_rdy[N] = rdy4;
  assign rdy2  = !v2_r  || rot_rdy[0];
  assign rdy1  = !v1_r  || rdy2;
  assign in_ready = rdy1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r  <= 1'b0;
      v2_r  <= 1'b0;
      v4_r  <= 1'b0;
      v5_r  <= 1'b0;
      v6_r  <= 1'b0;
      v7_r  <= 1'b0;
      v8_r  <= 1'b0;
      v9_r  <= 1'b0;
      v10_r <= 1'b0;
      v11_r <= 1'b0;
      v12_r <= 1'b0;
    end else begin
      if (rdy1)  v1_r  <= in_valid;
      if (rdy2)  v2_r  <= v1_r;
      if (rdy4)  v4_r  <= rot_v[N];
      if (rdy5)  v5_r  <= v4_r;
      if (rdy6)  v6_r  <= v5_r;
      if (rdy7)  v7_r  <= v6_r;
      if (rdy8)  v8_r  <= v7_r;
      if (rdy9)  v9_r  <= vec_v[N];
      if (rdy10) v10_r <= v9_r;
      if (rdy11) v11_r <= v10_r;
      if (rdy12) v12_r <= v11_r;
    end
  end

  // stage 1, 2
  always_ff @(posedge clk) begin
    if (rdy1 && in_valid) begin
      u1_r <= u1_nxt;
    end
    if (rdy2 && v1_r) begin
      for (int l = 0; l < 4; l++) begin
        p2_r[l] <= 62'(u1_r[l]) * 62'(CONV_M);
      end
    end
  end

  // rounding to Q2.30 feeds the first rotation cell
  always_comb begin
    for (int l = 0; l < 4; l++) begin
      rot_d[0][l].x = gcd_pkg::GAIN_Q30;
      rot_d[0][l].y = '0;
      rot_d[0][l].z = gcd_pkg::cw_t'((p2_r[l] + (62'd1 << 29)) >> 30);
    end
  end
  assign rot_v[0] = v2_r;

  for (genvar k = 0; k < N; k++) begin : g_rot
    gcd_rot_cell #(.STAGE(k)) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (rot_v[k]),
      .in_ready  (rot_rdy[k]),
      .in_data   (rot_d[k]),
      .out_valid (rot_v[k+1]),
      .out_ready (rot_rdy[k+1]),
      .out_data  (rot_d[k+1])
    );
  end

  // lanes: 0 half lat diff, 1 half lon diff, 2 and 3 latitudes
  always_ff @(posedge clk) begin
    if (rdy4 && rot_v[N]) begin
      sa4_r <= clamp_mag(rot_d[N][0].y);
      sb4_r <= clamp_mag(rot_d[N][1].y);
      c14_r <= clamp_unit(rot_d[N][2].x);
      c24_r <= clamp_unit(rot_d[N][3].x);
    end
    if (rdy5 && v4_r) begin
      p15_r <= 62'(sa4_r) * 62'(sa4_r);
      t5_r  <= 31'((62'(c14_r) * 62'(c24_r)) >> 30);
      uu5_r <= 31'((62'(sb4_r) * 62'(sb4_r)) >> 30);
    end
    if (rdy6 && v5_r) begin
      p16_r <= p15_r;
      tu6_r <= 62'(t5_r) * 62'(uu5_r);
    end
    if (rdy7 && v6_r) begin
      hs7_r <= p16_r + tu6_r;
    end
    if (rdy8 && v7_r) begin
      h8_r <= h8_nxt;
      g8_r <= ONE_Q60 - h8_nxt;
    end
  end

  assign h8_nxt = (hs7_r > ONE_Q60) ? ONE_Q60 : hs7_r;

  // lane 0: sqrt(1 - h), lane 1: sqrt(h)
  always_comb begin
    sq_d[0][0].n   = g8_r;
    sq_d[0][0].res = '0;
    sq_d[0][1].n   = h8_r;
    sq_d[0][1].res = '0;
  end
  assign sq_v[0] = v8_r;

  for (genvar k = 0; k < SQ; k++) begin : g_sqrt
    gcd_sqrt_cell #(.STAGE(k)) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (sq_v[k]),
      .in_ready  (sq_rdy[k]),
      .in_data   (sq_d[k]),
      .out_valid (sq_v[k+1]),
      .out_ready (sq_rdy[k+1]),
      .out_data  (sq_d[k+1])
    );
  end

  // asin(r) as atan2(r, q)
  always_comb begin
    vec_d[0].x = gcd_pkg::cw_t'(sq_d[SQ][0].res[30:0]);
    vec_d[0].y = gcd_pkg::cw_t'(sq_d[SQ][1].res[30:0]);
    vec_d[0].z = '0;
  end
  assign vec_v[0] = sq_v[SQ];

  for (genvar k = 0; k < N; k++) begin : g_vec
    gcd_vec_cell #(.STAGE(k)) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (vec_v[k]),
      .in_ready  (vec_rdy[k]),
      .in_data   (vec_d[k]),
      .out_valid (vec_v[k+1]),
      .out_ready (vec_rdy[k+1]),
      .out_data  (vec_d[k+1])
    );
  end

  assign zc = vec_d[N].z[gcd_pkg::CW-1] ? 31'd0 : vec_d[N].z[30:0];

  // tenths of meters, then divide by ten via reciprocal
  always_ff @(posedge clk) begin
    if (rdy9 && vec_v[N]) begin
      p9_r <= 58'(zc) * TWO_RADIUS_DM;
    end
    if (rdy10 && v9_r) begin
      tenths10_r <= 28'((p9_r + (58'd1 << 29)) >> 30);
    end
    if (rdy11 && v10_r) begin
      q11_r <= 64'(tenths10_r) * RECIP_10;
    end
    if (rdy12 && v11_r) begin
      dist12_r <= 25'(q11_r >> 35);
    end
  end

  assign out_valid           = v12_r;
  assign out_distance_meters = dist12_r;

endmodule

[bench/great_circle_distance_top_tb.sv]
`timescale 1ns / 1ps

module great_circle_distance_top_tb;

  localparam int STAGES  = gcd_pkg::CORDIC_STAGES_DEF;
  localparam int LATENCY = 2 * STAGES + 42;
  localparam longint LAT_MAX = 900000000;
  localparam longint HALF_TURN = 1800000000;
  localparam longint FULL_TURN = 64'sd3600000000;
  localparam longint ONE_Q30 = 64'd1 << 30;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic signed [30:0] in_first_latitude;
  logic signed [31:0] in_first_longitude;
  logic signed [30:0] in_second_latitude;
  logic signed [31:0] in_second_longitude;
  logic               out_valid;
  logic               out_ready;
  logic [24:0]        out_distance_meters;

  great_circle_distance_top DUT (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_first_latitude   (in_first_latitude),
    .in_first_longitude  (in_first_longitude),
    .in_second_latitude  (in_second_latitude),
    .in_second_longitude (in_second_longitude),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_distance_meters (out_distance_meters)
  );

  logic [24:0] pending_distances[$];
  int          errors;
  bit          hold_off_req;
  int          burst_left;

  initial clk = 1'b0;
  always #6 clk = ~clk;

  function automatic longint shr_floor(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint atan_entry(int i);
    longint tbl[10] = '{
      64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76,
      64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD
    };
    if (i < 10) return tbl[i];
    if (i <= 30) return 64'sd1 << (30 - i);
    return 0;
  endfunction

  // units of 1e-7 degree to half-angle radians, Q30
  function automatic longint units_to_half_rad(longint units);
    logic [63:0] pi_q60;
    logic [63:0] m;
    logic [63:0] p;
    pi_q60 = 64'h3243F6A8885A308D;
    m = (pi_q60 + 64'd1800000000) / 64'd3600000000;
    p = 64'(units) * m + (64'd1 << 29);
    return longint'(p >> 30);
  endfunction

  task automatic cordic_rotate(input longint ang, output longint c, output longint s);
    longint x, y, z, dx, dy;
    x = 64'h26DD3B6A;
    y = 0;
    z = ang;
    for (int i = 0; i < STAGES; i++) begin
      dx = shr_floor(y, i);
      dy = shr_floor(x, i);
      if (z >= 0) begin
        x -= dx; y += dy; z -= atan_entry(i);
      end else begin
        x += dx; y -= dy; z += atan_entry(i);
      end
    end
    c = x;
    s = y;
  endtask

  function automatic logic [63:0] floor_sqrt(logic [63:0] n);
    logic [63:0] res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic longint vector_angle(longint x, longint y);
    longint z, dx, dy;
    z = 0;
    for (int i = 0; i < STAGES; i++) begin
      dx = shr_floor(y, i);
      dy = shr_floor(x, i);
      if (y > 0) begin
        x += dx; y -= dy; z += atan_entry(i);
      end else begin
        x -= dx; y += dy; z -= atan_entry(i);
      end
    end
    return z;
  endfunction

  function automatic longint sat_lat(logic signed [30:0] v);
    longint l;
    l = v;
    if (l > LAT_MAX) return LAT_MAX;
    if (l < -LAT_MAX) return -LAT_MAX;
    return l;
  endfunction

  function automatic longint magnitude(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic logic [63:0] clamp_unit(longint v);
    if (v < 0) return 0;
    if (v > ONE_Q30) return ONE_Q30;
    return v;
  endfunction

  task automatic predict_distance(input logic signed [30:0] lat_a, input logic signed [31:0] lon_a,
                                  input logic signed [30:0] lat_b, input logic signed [31:0] lon_b,
                                  output logic [24:0] meters);
    longint la, lb, dlon, c, s, z;
    logic [63:0] sa, sb, c1, c2, t, u, h, r, q, tenths;
    la = sat_lat(lat_a);
    lb = sat_lat(lat_b);
    dlon = longint'(lon_a) - longint'(lon_b);
    if (dlon > HALF_TURN) dlon -= FULL_TURN;
    else if (dlon < -HALF_TURN) dlon += FULL_TURN;
    cordic_rotate(units_to_half_rad(magnitude(la - lb)), c, s);
    sa = magnitude(s);
    cordic_rotate(units_to_half_rad(magnitude(dlon)), c, s);
    sb = magnitude(s);
    cordic_rotate(units_to_half_rad(2 * magnitude(la)), c, s);
    c1 = clamp_unit(c);
    cordic_rotate(units_to_half_rad(2 * magnitude(lb)), c, s);
    c2 = clamp_unit(c);
    if (sa > ONE_Q30) sa = ONE_Q30;
    if (sb > ONE_Q30) sb = ONE_Q30;
    t = (c1 * c2) >> 30;
    u = (sb * sb) >> 30;
    h = sa * sa + t * u;
    if (h > (64'd1 << 60)) h = 64'd1 << 60;
    r = floor_sqrt(h);
    q = floor_sqrt((64'd1 << 60) - h);
    z = vector_angle(longint'(q), longint'(r));
    if (z < 0) z = 0;
    tenths = (64'(z) * 64'd127562740 + (64'd1 << 29)) >> 30;
    meters = 25'(tenths / 10);
  endtask

  task automatic send_pair(input logic signed [30:0] lat_a, input logic signed [31:0] lon_a,
                           input logic signed [30:0] lat_b, input logic signed [31:0] lon_b);
    logic [24:0] exp_m;
    int          gap;
    // random gaps between bursts
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 30);
    end
    burst_left--;
    predict_distance(lat_a, lon_a, lat_b, lon_b, exp_m);
    in_valid            <= 1'b1;
    in_first_latitude   <= lat_a;
    in_first_longitude  <= lon_a;
    in_second_latitude  <= lat_b;
    in_second_longitude <= lon_b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_distances.push_back(exp_m);
  endtask

  function automatic logic signed [30:0] rand_lat();
    case ($urandom_range(0, 9))
      0: return 31'($urandom);
      1: return $urandom_range(0, 1) ? 31'sd900000000 : -31'sd900000000;
      default: return 31'(longint'($urandom_range(0, 1800000000)) - LAT_MAX);
    endcase
  endfunction

  function automatic logic signed [31:0] rand_lon();
    case ($urandom_range(0, 9))
      0: return 32'($urandom);
      1: return $urandom_range(0, 1) ? 32'sd1800000000 : -32'sd1800000000;
      default: return 32'(longint'($urandom) % (2 * HALF_TURN + 1) - HALF_TURN);
    endcase
  endfunction

  task automatic test_directed();
    send_pair('0, '0, '0, '0);
    send_pair(31'sd900000000, '0, -31'sd900000000, '0);
    send_pair('0, 32'sd1800000000, '0, -32'sd1800000000);
    send_pair('0, '0, '0, 32'sd1800000000);
    send_pair('0, -32'sd1800000000, '0, 32'sd1800000000);
    send_pair(31'sd900000000, 32'sd1234, 31'sd900000000, -32'sd5678);
    send_pair(31'h3FFFFFFF, 32'h7FFFFFFF, 31'h40000000, 32'h80000000);
    send_pair(31'h40000000, 32'h80000000, 31'h3FFFFFFF, 32'h7FFFFFFF);
    send_pair(-31'sd1, -32'sd1, 31'sd1, 32'sd1);
    send_pair(31'sd1, '0, '0, '0);
    send_pair(31'sd450000000, 32'sd900000000, -31'sd450000000, -32'sd900000000);
    send_pair(31'sd123456789, 32'sd1700000000, 31'sd123456789, -32'sd1700000000);
    send_pair(-31'sd900000000, 32'sd1800000000, 31'sd900000000, -32'sd1800000000);
    send_pair(31'sd0, 32'sd1800000000, 31'sd0, 32'sd0);
  endtask

  task automatic test_random(input int count);
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(0, 4) == 0)
        send_pair(rand_lat(), rand_lon(), rand_lat() ^ 31'($urandom_range(0, 1000)),
                  rand_lon());
      else
        send_pair(rand_lat(), rand_lon(), rand_lat(), rand_lon());
    end
  endtask

  // receiver holds off long enough for the pipeline to fill and back up
  task automatic test_backpressure();
    hold_off_req = 1'b1;
    test_random(200);
    hold_off_req = 1'b0;
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_distances.size() == 0) begin
        $error("distance_meters: unexpected item, actual %0d", out_distance_meters);
        errors++;
      end else begin
        if (out_distance_meters !== pending_distances[0]) begin
          $error("distance_meters: expected %0d actual %0d", pending_distances[0],
                 out_distance_meters);
          errors++;
        end
        void'(pending_distances.pop_front());
      end
    end
  end

  initial begin
    int stall_len;
    out_ready <= 1'b0;
    @(posedge rst_n);
    forever begin
      if (hold_off_req) begin
        out_ready <= 1'b0;
        repeat (400) @(posedge clk);
        hold_off_req = 1'b0;
      end
      stall_len = $urandom_range(0, 3) == 0 ? $urandom_range(1, 8) : 0;
      if (stall_len > 0) begin
        out_ready <= 1'b0;
        repeat (stall_len) @(posedge clk);
      end
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 40)) @(posedge clk);
    end
  end

  initial begin
    #20ms;
    $display("great_circle_distance_top_tb NOT OK");
    $finish;
  end

  initial begin
    errors = 0;
    burst_left = 0;
    hold_off_req = 1'b0;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_first_latitude <= '0;
    in_first_longitude <= '0;
    in_second_latitude <= '0;
    in_second_longitude <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(450);
    test_backpressure();
    test_random(486);
    in_valid <= 1'b0;
    while (pending_distances.size() != 0) @(posedge clk);
    repeat (LATENCY + 20) @(posedge clk);
    if (errors == 0 && pending_distances.size() == 0) begin
      $display("great_circle_distance_top_tb OK");
    end else begin
      $display("great_circle_distance_top_tb NOT OK");
    end
    $finish;
  end

endmodule
